### rtl/core/spq_pkg.sv
package spq_pkg;

	// number of cells in the chain
	localparam int DEPTH = 64;
	// entry count must hold DEPTH itself
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int OCC_W = 7;
	localparam int VAL_W = 32;
	localparam int PRI_W = 8;

	localparam logic [1:0] OP_ENQUEUE = 2'd0;
	localparam logic [1:0] OP_DEQUEUE = 2'd1;
	localparam logic [1:0] OP_PEEK    = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic               valid;
		logic [VAL_W-1:0]   value;
		logic [PRI_W-1:0]   prio;
	} entry_t;

	// broadcast to every cell
	typedef struct packed {
		logic               ins;
		logic               rem;
		logic [VAL_W-1:0]   value;
		logic [PRI_W-1:0]   prio;
	} cell_ctl_t;

endpackage

### rtl/core/sorted_priority_queue.sv
// Channel  Handshake          Words
// -------  -----------------  ---------------------------------------
// command  start / busy       opcode, item_value, item_priority
// result   done (strobe)      head_value, status, occupancy
//
// A command is taken on any edge with start high; busy stays low.
// Every command gives one result word, strobed on done the next cycle.
// All DEPTH cells compare and shift in the same edge, so one command per cycle.
// Reset (arst_n low) empties the queue; stored words are not cleared.
// The receiver cannot stall: done lasts exactly one cycle.
module sorted_priority_queue
	import spq_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               opcode,
	input  logic signed [VAL_W-1:0]  item_value,
	input  logic [PRI_W-1:0]         item_priority,
	output logic                     done,
	output logic signed [VAL_W-1:0]  head_value,
	output logic [1:0]               status,
	output logic [OCC_W-1:0]         occupancy
);

	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	cell_ctl_t        ctl;
	entry_t           ent      [DEPTH];
	logic             go       [DEPTH];
	entry_t           left_ent [DEPTH];
	logic             left_go  [DEPTH];
	entry_t           right_ent[DEPTH];

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic             accept;
	logic             full;
	logic             empty;
	logic [VAL_W-1:0] head_d;
	logic [1:0]       status_d;

	logic             done_q;
	logic [VAL_W-1:0] head_q;
	logic [1:0]       status_q;
	logic [OCC_W-1:0] occ_q;

	// never busy: a command is taken whenever start is high
	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (count_q == FULL_CNT);
	assign empty  = (count_q == '0);

	// decode: what the chain does this edge and what gets reported
	always_comb begin
		ctl.ins   = 1'b0;
		ctl.rem   = 1'b0;
		ctl.value = item_value;
		ctl.prio  = item_priority;
		count_d   = count_q;
		head_d    = '0;
		status_d  = ST_OK;
		if (accept) begin
			case (opcode)
				OP_ENQUEUE: begin
					if (full) begin
						status_d = ST_FULL;
					end else begin
						ctl.ins = 1'b1;
						count_d = count_q + 1'b1;
					end
				end
				OP_DEQUEUE: begin
					if (empty) begin
						status_d = ST_EMPTY;
					end else begin
						ctl.rem = 1'b1;
						head_d  = ent[0].value;
						count_d = count_q - 1'b1;
					end
				end
				OP_PEEK: begin
					if (empty) begin
						status_d = ST_EMPTY;
					end else begin
						head_d = ent[0].value;
					end
				end
				default: begin
					// unused code: no-op, reports ok and the count
				end
			endcase
		end
	end

	// neighbor wiring; chain ends see an empty slot
	always_comb begin
		for (int k = 0; k < DEPTH; k++) begin
			if (k == 0) begin
				left_ent[k] = '0;
				left_go[k]  = 1'b0;
			end else begin
				left_ent[k] = ent[k-1];
				left_go[k]  = go[k-1];
			end
			if (k == DEPTH - 1) begin
				right_ent[k] = '0;
			end else begin
				right_ent[k] = ent[k+1];
			end
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		spq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.left_ent  (left_ent[g]),
			.left_go   (left_go[g]),
			.right_ent (right_ent[g]),
			.ent       (ent[g]),
			.go        (go[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			done_q  <= accept;
		end
	end

	// result word; occupancy is the count after the command, low 7 bits
	always_ff @(posedge clk) begin
		if (accept) begin
			head_q   <= head_d;
			status_q <= status_d;
			occ_q    <= OCC_W'(count_d);
		end
	end

	assign done       = done_q;
	assign head_value = head_q;
	assign status     = status_q;
	assign occupancy  = occ_q;

endmodule

### rtl/core/spq_cell.sv
module spq_cell
	import spq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  entry_t    left_ent,
	input  logic      left_go,
	input  entry_t    right_ent,
	output entry_t    ent,
	output logic      go
);

	logic             valid_q;
	logic [VAL_W-1:0] value_q;
	logic [PRI_W-1:0] prio_q;

	// new word lands here or further left; ties stay ahead
	assign go  = !valid_q || (prio_q < ctl.prio);
	assign ent = {valid_q, value_q, prio_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.ins) begin
			if (left_go) begin
				valid_q <= left_ent.valid;
			end else if (go) begin
				valid_q <= 1'b1;
			end
		end else if (ctl.rem) begin
			valid_q <= right_ent.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (left_go) begin
				value_q <= left_ent.value;
				prio_q  <= left_ent.prio;
			end else if (go) begin
				value_q <= ctl.value;
				prio_q  <= ctl.prio;
			end
		end else if (ctl.rem) begin
			value_q <= right_ent.value;
			prio_q  <= right_ent.prio;
		end
	end

endmodule

### sim/sorted_priority_queue_test.sv
`timescale 1ns / 1ps

module sorted_priority_queue_test;
	import spq_pkg::*;

	// opcode 3 is not decoded by the block: it reports occupancy and does nothing
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_CMDS = 750;
	// longest quiet stretch of a correct run is the largest random gap plus the wait for the result
	localparam int STALL_LIMIT = 200;

	typedef struct packed {
		logic [1:0]               op;
		logic signed [VAL_W-1:0]  value;
		logic [PRI_W-1:0]         prio;
	} cmd_t;

	typedef struct packed {
		logic signed [VAL_W-1:0]  value;
		logic [1:0]               status;
		logic [OCC_W-1:0]         occ;
	} result_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     busy;
	logic [1:0]               opcode = OP_PEEK;
	logic signed [VAL_W-1:0]  item_value = '0;
	logic [PRI_W-1:0]         item_priority = '0;
	logic                     done;
	logic signed [VAL_W-1:0]  head_value;
	logic [1:0]               status;
	logic [OCC_W-1:0]         occupancy;

	sorted_priority_queue uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.opcode        (opcode),
		.item_value    (item_value),
		.item_priority (item_priority),
		.done          (done),
		.head_value    (head_value),
		.status        (status),
		.occupancy     (occupancy)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Shadow queue: slot 0 is the head, kept sorted highest priority first
	// ------------------------------------------------------------------
	logic signed [VAL_W-1:0]  shadow_value [DEPTH];
	logic [PRI_W-1:0]         shadow_prio  [DEPTH];
	int                       shadow_count = 0;

	cmd_t     pending_cmds[$];       // words not yet offered to the block
	result_t  expected_results[$];   // one per accepted word, oldest first

	int  errors = 0;
	int  n_cmds = 0;
	int  n_results = 0;
	int  n_full = 0;
	int  n_empty = 0;
	int  n_served = 0;
	int  peak_count = 0;

	// Apply one command word to the shadow queue, return the result it must produce.
	function automatic result_t serve_command(logic [1:0] op, logic signed [VAL_W-1:0] v,
			logic [PRI_W-1:0] p);
		result_t r;
		int pos;
		int k;
		r.value = '0;
		r.status = ST_OK;
		case (op)
			OP_ENQUEUE: begin
				if (shadow_count >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					// new word goes ahead of the first strictly lower priority,
					// i.e. behind every equal one already held
					pos = shadow_count;
					for (k = 0; k < shadow_count; k++) begin
						if (shadow_prio[k] < p) begin
							pos = k;
							break;
						end
					end
					for (k = shadow_count; k > pos; k--) begin
						shadow_value[k] = shadow_value[k-1];
						shadow_prio[k] = shadow_prio[k-1];
					end
					shadow_value[pos] = v;
					shadow_prio[pos] = p;
					shadow_count++;
				end
			end
			OP_DEQUEUE, OP_PEEK: begin
				if (shadow_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.value = shadow_value[0];
					if (op == OP_DEQUEUE) begin
						for (k = 1; k < shadow_count; k++) begin
							shadow_value[k-1] = shadow_value[k];
							shadow_prio[k-1] = shadow_prio[k];
						end
						shadow_count--;
					end
				end
			end
			default: ;
		endcase
		r.occ = OCC_W'(shadow_count);
		return r;
	endfunction

	function automatic void queue_cmd(logic [1:0] op, logic signed [VAL_W-1:0] v,
			logic [PRI_W-1:0] p);
		cmd_t c;
		c.op = op;
		c.value = v;
		c.prio = p;
		pending_cmds.push_back(c);
	endfunction

	// narrow ranges pile up ties, so arrival order among equals gets exercised
	function automatic logic [PRI_W-1:0] pick_prio(bit narrow);
		logic [PRI_W-1:0] p;
		case ($urandom_range(0, 7))
			0: p = '0;
			1: p = '1;
			default: p = narrow ? PRI_W'($urandom_range(0, 3)) : PRI_W'($urandom);
		endcase
		return p;
	endfunction

	// ------------------------------------------------------------------
	// Driver: offers words at the falling edge, with a random gap after each
	// ------------------------------------------------------------------
	logic  cmd_taken = 1'b0;   // word on the ports was accepted at the last rising edge
	int    gap_left = 0;
	bit    no_gaps = 1'b0;

	always @(negedge clk) begin
		cmd_t nxt;
		// hold the word while it waits on busy
		if (arst_n && !(start && !cmd_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pending_cmds.size() != 0) begin
				nxt = pending_cmds.pop_front();
				start <= 1'b1;
				opcode <= nxt.op;
				item_value <= nxt.value;
				item_priority <= nxt.prio;
				// now and then switch between gapped and back-to-back stretches
				if ($urandom_range(0, 39) == 0)
					no_gaps = !no_gaps;
				gap_left = no_gaps ? 0 : $urandom_range(0, 10);
			end else begin
				start <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: check the strobed result first, then predict for the word
	// accepted on this same edge (its result is strobed on the next edge)
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		result_t want;
		result_t got;
		if (arst_n) begin
			if (done) begin
				n_results++;
				got.value = head_value;
				got.status = status;
				got.occ = occupancy;
				if (expected_results.size() == 0) begin
					errors++;
					$display("%t: result with nothing expected: head_value %0d status %0d occupancy %0d",
						$time, got.value, got.status, got.occ);
				end else begin
					want = expected_results.pop_front();
					if (got.value !== want.value) begin
						errors++;
						$display("%t: head_value expected %0d actual %0d",
							$time, want.value, got.value);
					end
					if (got.status !== want.status) begin
						errors++;
						$display("%t: status expected %0d actual %0d",
							$time, want.status, got.status);
					end
					if (got.occ !== want.occ) begin
						errors++;
						$display("%t: occupancy expected %0d actual %0d",
							$time, want.occ, got.occ);
					end
				end
			end
			cmd_taken <= start && !busy;
			if (start && !busy) begin
				n_cmds++;
				want = serve_command(opcode, item_value, item_priority);
				case (want.status)
					ST_FULL:  n_full++;
					ST_EMPTY: n_empty++;
					default:  if (opcode == OP_DEQUEUE || opcode == OP_PEEK) n_served++;
				endcase
				if (shadow_count > peak_count)
					peak_count = shadow_count;
				expected_results.push_back(want);
			end
		end
	end

	// Watchdog: too long with neither a word taken nor a result strobed.
	int stall_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("%t: no activity for %0d cycles, %0d results outstanding",
					$time, stall_cycles, expected_results.size());
				$display("CHECKS FAILED");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------
	initial begin
		int made;
		int seg_len;
		int mode;
		int pick;
		bit narrow;

		// directed: empty cases, extremes, ties at head and tail, full drain
		queue_cmd(OP_PEEK, 32'sd7, 8'd9);
		queue_cmd(OP_DEQUEUE, -32'sd1, 8'd255);
		queue_cmd(OP_UNUSED, 32'sd5, 8'd1);
		queue_cmd(OP_ENQUEUE, 32'sh7FFF_FFFF, 8'd0);
		queue_cmd(OP_ENQUEUE, 32'sh8000_0000, 8'd255);
		queue_cmd(OP_ENQUEUE, 32'sd0, 8'd128);
		queue_cmd(OP_ENQUEUE, -32'sd1, 8'd128);
		queue_cmd(OP_ENQUEUE, 32'sd1, 8'd128);
		queue_cmd(OP_ENQUEUE, 32'sh5555_5555, 8'd0);
		queue_cmd(OP_ENQUEUE, 32'shAAAA_AAAA, 8'd255);
		queue_cmd(OP_PEEK, 32'sd0, 8'd0);
		queue_cmd(OP_UNUSED, -32'sd1, 8'd255);
		repeat (8)
			queue_cmd(OP_DEQUEUE, 32'sd0, 8'd0);
		queue_cmd(OP_PEEK, 32'sd0, 8'd0);
		queue_cmd(OP_ENQUEUE, 32'sd42, 8'd1);
		queue_cmd(OP_DEQUEUE, 32'sd0, 8'd0);

		// random: fill past full once, then fill / drain / mixed segments
		made = 0;
		repeat (70) begin
			queue_cmd(OP_ENQUEUE, $urandom, pick_prio($urandom_range(0, 1)));
			made++;
		end
		while (made < RANDOM_CMDS) begin
			mode = $urandom_range(0, 2);
			seg_len = $urandom_range(20, 80);
			narrow = $urandom_range(0, 1);
			repeat (seg_len) begin
				pick = $urandom_range(0, 99);
				case (mode)
					0:       pick = pick < 85 ? 0 : pick < 93 ? 1 : pick < 98 ? 2 : 3;
					1:       pick = pick < 10 ? 0 : pick < 85 ? 1 : pick < 97 ? 2 : 3;
					default: pick = pick < 40 ? 0 : pick < 80 ? 1 : pick < 95 ? 2 : 3;
				endcase
				case (pick)
					0:       queue_cmd(OP_ENQUEUE, $urandom, pick_prio(narrow));
					1:       queue_cmd(OP_DEQUEUE, $urandom, PRI_W'($urandom));
					2:       queue_cmd(OP_PEEK, $urandom, PRI_W'($urandom));
					default: queue_cmd(OP_UNUSED, $urandom, PRI_W'($urandom));
				endcase
				made++;
			end
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_cmds.size() != 0 || start)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		// the extra edges after the last result catch any stray strobe
		repeat (4) @(posedge clk);

		$display("Ran %0d commands, %0d results: %0d heads served, %0d full, %0d empty.",
			n_cmds, n_results, n_served, n_full, n_empty);
		$display("Queue depth peaked at %0d of %0d entries.", peak_count, DEPTH);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches", errors);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue.sv
sim/sorted_priority_queue_test.sv
